[sv/assert_macros.svh]
// assertion helpers for the checker in cts_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every edge outside reset
`define CHK_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define CHK_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[sv/cts_pkg.sv]
`timescale 1ns / 1ps

package cts_pkg;

  localparam logic [2:0] REQ_ADD   = 3'd0;
  localparam logic [2:0] REQ_KILL  = 3'd1;
  localparam logic [2:0] REQ_EXIT  = 3'd2;
  localparam logic [2:0] REQ_SLEEP = 3'd3;
  localparam logic [2:0] REQ_NEXT  = 3'd4;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_NO_CURRENT = 3'd2;
  localparam logic [2:0] ST_DISPATCHED = 3'd3;
  localparam logic [2:0] ST_PASS_END   = 3'd4;

  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ADD,
    S_RD,
    S_CHK,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_KILL,
    OP_EXIT,
    OP_SLEEP,
    OP_NOP_DONE,
    OP_ADD_INIT,
    OP_ADD_CLAIM,
    OP_ADD_FULL,
    OP_NEXT_INIT,
    OP_IDX_INC,
    OP_DISPATCH,
    OP_PASS_END,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    logic [2:0] req;
    logic       slot_free;
    logic       idx_last;
    logic       hit;
    logic       scan_over;
  } dp_status_t;

endpackage

[sv/cts_ram.sv]
`timescale 1ns / 1ps

module cts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/cts_ctrl.sv]
`timescale 1ns / 1ps

module cts_ctrl import cts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t st,
  output op_t        op
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        case (st.req)
          REQ_ADD:  state_next = S_ADD;
          REQ_NEXT: state_next = st.scan_over ? S_DONE : S_RD;
          default:  state_next = S_DONE;
        endcase
      end
      S_ADD:  if (st.slot_free || st.idx_last) state_next = S_DONE;
      S_RD:   state_next = S_CHK;
      S_CHK:  state_next = (st.hit || st.idx_last) ? S_DONE : S_RD;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) op = OP_LOAD;
      end
      S_EXEC: begin
        unique case (st.req)
          REQ_ADD:   op = OP_ADD_INIT;
          REQ_KILL:  op = OP_KILL;
          REQ_EXIT:  op = OP_EXIT;
          REQ_SLEEP: op = OP_SLEEP;
          REQ_NEXT:  op = st.scan_over ? OP_PASS_END : OP_NEXT_INIT;
          default:   op = OP_NOP_DONE;
        endcase
      end
      S_ADD: begin
        if (st.slot_free)     op = OP_ADD_CLAIM;
        else if (st.idx_last) op = OP_ADD_FULL;
        else                  op = OP_IDX_INC;
      end
      S_RD: op = OP_NONE;
      S_CHK: begin
        if (st.hit)           op = OP_DISPATCH;
        else if (st.idx_last) op = OP_PASS_END;
        else                  op = OP_IDX_INC;
      end
      S_DONE: if (out_free) op = OP_OUT_LOAD;
      default: op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_OUT_LOAD) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/cts_dp.sv]
`timescale 1ns / 1ps

module cts_dp import cts_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  output dp_status_t  st,
  input  logic [2:0]  req_type,
  input  logic [2:0]  slot,
  input  logic [14:0] duration,
  input  logic        in_seconds,
  input  logic [31:0] now,
  output logic [2:0]  status,
  output logic [2:0]  slot_out,
  output logic        idle
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SW = $clog2(SLOT_COUNT + 1);

  // request held for the whole operation
  logic [2:0]  req_r;
  logic [2:0]  slot_r;
  logic [14:0] dur_r;
  logic        sec_r;
  logic [31:0] now_r;

  logic [SLOT_COUNT-1:0] slot_valid;
  logic                  cur_valid;
  logic [IW-1:0]         cur_idx;
  logic [SW-1:0]         scan_pos;
  logic                  ran_in_pass;
  logic [IW-1:0]         idx;

  logic [2:0] pend_status;
  logic [2:0] pend_slot;
  logic       pend_idle;

  logic          we;
  logic [IW-1:0] waddr;
  logic [31:0]   wdata;
  logic [31:0]   rdata;

  logic [IW-1:0] kidx;
  logic          kill_ok;
  logic [24:0]   len_s;
  logic [31:0]   len;

  assign kidx    = IW'(slot_r);
  assign kill_ok = 32'(slot_r) < SLOT_COUNT;
  assign len_s   = 25'(dur_r) * 25'(MS_PER_SECOND);
  assign len     = sec_r ? 32'(len_s) : 32'(dur_r);

  assign st.req       = req_r;
  assign st.slot_free = !slot_valid[idx];
  assign st.idx_last  = idx == IW'(SLOT_COUNT - 1);
  assign st.hit       = slot_valid[idx] && (rdata <= now_r);
  assign st.scan_over = scan_pos >= SW'(SLOT_COUNT);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    case (op)
      OP_ADD_CLAIM, OP_DISPATCH: we = 1'b1;
      OP_SLEEP: begin
        we    = cur_valid;
        waddr = cur_idx;
        wdata = now_r + len;
      end
      default: we = 1'b0;
    endcase
  end

  cts_ram #(
    .WIDTH(32),
    .DEPTH(SLOT_COUNT)
  ) u_wake (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      cur_valid   <= 1'b0;
      scan_pos    <= '0;
      ran_in_pass <= 1'b0;
    end else begin
      unique case (op)
        OP_KILL: begin
          if (kill_ok) begin
            slot_valid[kidx] <= 1'b0;
            if (cur_valid && cur_idx == kidx) cur_valid <= 1'b0;
          end
        end
        OP_EXIT: begin
          if (cur_valid) begin
            slot_valid[cur_idx] <= 1'b0;
            cur_valid           <= 1'b0;
          end
        end
        OP_ADD_CLAIM: slot_valid[idx] <= 1'b1;
        OP_DISPATCH: begin
          cur_valid   <= 1'b1;
          ran_in_pass <= 1'b1;
          scan_pos    <= SW'(idx) + SW'(1);
        end
        OP_PASS_END: begin
          scan_pos    <= '0;
          ran_in_pass <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        req_r  <= req_type;
        slot_r <= slot;
        dur_r  <= duration;
        sec_r  <= in_seconds;
        now_r  <= now;
      end
      OP_KILL, OP_NOP_DONE: begin
        pend_status <= ST_DONE;
        pend_slot   <= '0;
        pend_idle   <= 1'b0;
      end
      OP_EXIT, OP_SLEEP: begin
        pend_status <= cur_valid ? ST_DONE : ST_NO_CURRENT;
        pend_slot   <= '0;
        pend_idle   <= 1'b0;
      end
      OP_ADD_INIT:  idx <= '0;
      OP_NEXT_INIT: idx <= scan_pos[IW-1:0];
      OP_IDX_INC:   idx <= idx + IW'(1);
      OP_ADD_CLAIM: begin
        pend_status <= ST_DONE;
        pend_slot   <= 3'(idx);
        pend_idle   <= 1'b0;
      end
      OP_ADD_FULL: begin
        pend_status <= ST_FULL;
        pend_slot   <= '0;
        pend_idle   <= 1'b0;
      end
      OP_DISPATCH: begin
        cur_idx     <= idx;
        pend_status <= ST_DISPATCHED;
        pend_slot   <= 3'(idx);
        pend_idle   <= 1'b0;
      end
      OP_PASS_END: begin
        pend_status <= ST_PASS_END;
        pend_slot   <= '0;
        pend_idle   <= !ran_in_pass;
      end
      OP_OUT_LOAD: begin
        status   <= pend_status;
        slot_out <= pend_slot;
        idle     <= pend_idle;
      end
      default: ;
    endcase
  end

endmodule

[sv/cooperative_task_scheduler_unit.sv]
`timescale 1ns / 1ps
// channel   direction  handshake            fields
// request   in         in_valid / in_stall  req_type slot duration in_seconds now
// result    out        out_valid / out_stall status slot_out idle
//
// one item at a time; kill, exit, sleep and unknown requests pass through S_EXEC and S_DONE
// add walks the valid bits one slot a cycle, from slot 0 to a free slot or the last slot
// next reads one wake time at a time from the wake ram through S_RD and S_CHK,
// starting at the scan position and stopping at the first due task or the last slot
// synchronous reset empties the table; wake ram needs no clearing
// a finished result waits in the output register while the next item is taken

module cooperative_task_scheduler_unit import cts_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [2:0]  slot,
  input  logic [14:0] duration,
  input  logic        in_seconds,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [2:0]  slot_out,
  output logic        idle
);

  op_t        op;
  dp_status_t st;

  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .st       (st),
    .op       (op)
  );

  cts_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .st        (st),
    .req_type  (req_type),
    .slot      (slot),
    .duration  (duration),
    .in_seconds(in_seconds),
    .now       (now),
    .status    (status),
    .slot_out  (slot_out),
    .idle      (idle)
  );

endmodule

[sv/cts_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cts_checker import cts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [2:0]  slot_out,
  input logic        idle
);

  // result must wait until taken
  `CHK_HOLDS(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result dropped")

  // idle flag only reported at the end of a pass
  `CHK_NEVER(a_idle_pass, clk, rst, out_valid && idle && status != ST_PASS_END, "stray idle")

  // only add and dispatch name a slot
  `CHK_NEVER(a_slot_zero, clk, rst,
    out_valid && slot_out != 3'd0 && status != ST_DONE && status != ST_DISPATCHED,
    "slot on non-slot result")

  // the request channel must stall right after an item is accepted
  `CHK_HOLDS(a_one_item, clk, rst, in_valid && !in_stall |=> in_stall, "item overlap")

endmodule

bind cooperative_task_scheduler_unit cts_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .status   (status),
  .slot_out (slot_out),
  .idle     (idle)
);

[sim/scheduler_result_checker.sv]
`timescale 1ns / 1ps

module scheduler_result_checker import cts_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [2:0]  slot,
  input  logic [14:0] duration,
  input  logic        in_seconds,
  input  logic [31:0] now,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [2:0]  slot_out,
  input  logic        idle,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          dispatches,
  output int          full_answers
);

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_out;
    logic       idle;
  } sched_result_t;

  // shadow copy of the task table
  logic          slot_used [SLOT_COUNT];
  logic [31:0]   wake_at [SLOT_COUNT];
  logic [3:0]    running_slot;
  logic [3:0]    scan_from;
  logic          ran_this_pass;
  sched_result_t expected_results [$];

  int errors = 0;
  int checked = 0;
  int n_dispatch = 0;
  int n_full = 0;

  function automatic void release_slot(input logic [3:0] s);
    if (s < SLOT_COUNT) begin
      slot_used[s] = 1'b0;
      if (running_slot == s) running_slot = 4'(SLOT_COUNT);
    end
  endfunction

  function automatic sched_result_t predict_schedule(input logic [2:0] rt,
                                                     input logic [2:0] kill_slot,
                                                     input logic [14:0] dur,
                                                     input logic secs,
                                                     input logic [31:0] t_now);
    sched_result_t r;
    logic [31:0]   len;
    bit            found;
    r = '{ST_DONE, 3'd0, 1'b0};
    found = 1'b0;
    case (rt)
      REQ_ADD: begin
        r.status = ST_FULL;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!found && !slot_used[i]) begin
            slot_used[i] = 1'b1;
            wake_at[i] = '0;
            r.status = ST_DONE;
            r.slot_out = 3'(i);
            found = 1'b1;
          end
        end
      end
      REQ_KILL: release_slot({1'b0, kill_slot});
      REQ_EXIT: begin
        if (running_slot < SLOT_COUNT) release_slot(running_slot);
        else r.status = ST_NO_CURRENT;
      end
      REQ_SLEEP: begin
        if (running_slot < SLOT_COUNT) begin
          len = secs ? 32'(dur) * 32'(MS_PER_SECOND) : 32'(dur);
          wake_at[running_slot] = t_now + len;
        end else begin
          r.status = ST_NO_CURRENT;
        end
      end
      REQ_NEXT: begin
        r.status = ST_PASS_END;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!found && i >= scan_from && slot_used[i] && wake_at[i] <= t_now) begin
            wake_at[i] = '0;
            running_slot = 4'(i);
            ran_this_pass = 1'b1;
            scan_from = 4'(i + 1);
            r.status = ST_DISPATCHED;
            r.slot_out = 3'(i);
            found = 1'b1;
          end
        end
        if (!found) begin
          r.idle = !ran_this_pass;
          scan_from = '0;
          ran_this_pass = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_used[i] = 1'b0;
        wake_at[i] = '0;
      end
      running_slot = 4'(SLOT_COUNT);
      scan_from = '0;
      ran_this_pass = 1'b0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(predict_schedule(req_type, slot, duration, in_seconds,
                                                    now));
      if (out_valid && !out_stall) begin
        got = '{status, slot_out, idle};
        checked++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result %0d arrived with nothing expected: status %0d slot %0d idle %0d",
                     checked, got.status, got.slot_out, got.idle);
        end else begin
          want = expected_results.pop_front();
          if (want.status == ST_DISPATCHED) n_dispatch++;
          if (want.status == ST_FULL) n_full++;
          if (got.status !== want.status || got.slot_out !== want.slot_out ||
              got.idle !== want.idle) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d (status/slot/idle)",
                       checked, want.status, want.slot_out, want.idle,
                       got.status, got.slot_out, got.idle);
          end
        end
      end
    end
    fail_count   <= errors;
    pending      <= expected_results.size();
    results_seen <= checked;
    dispatches   <= n_dispatch;
    full_answers <= n_full;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import cts_pkg::*;

  localparam int SLOTS = 8;
  localparam int QUIET_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  req_type;
  logic [2:0]  slot;
  logic [14:0] duration;
  logic        in_seconds;
  logic [31:0] now;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [2:0]  slot_out;
  logic        idle;

  int fail_count;
  int pending;
  int results_seen;
  int dispatches;
  int full_answers;

  int          sent = 0;
  int          quiet_cycles = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  logic [31:0] sim_ms = '0;

  always #5 clk = ~clk;

  cooperative_task_scheduler_unit #(.SLOT_COUNT(SLOTS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .slot       (slot),
    .duration   (duration),
    .in_seconds (in_seconds),
    .now        (now),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .slot_out   (slot_out),
    .idle       (idle)
  );

  scheduler_result_checker #(.SLOT_COUNT(SLOTS)) result_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .slot         (slot),
    .duration     (duration),
    .in_seconds   (in_seconds),
    .now          (now),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot_out     (slot_out),
    .idle         (idle),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .dispatches   (dispatches),
    .full_answers (full_answers)
  );

  // hold the current item until it is taken
  task automatic send_item(input logic [2:0] rt, input logic [2:0] s, input logic [14:0] d,
                           input logic sec, input logic [31:0] t);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rt;
    slot       <= s;
    duration   <= d;
    in_seconds <= sec;
    now        <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // time mostly creeps forward so sleeping tasks wake again; rare jumps as noise
  task automatic random_request(input int add_pct);
    logic [2:0]  rt;
    logic [14:0] dur;
    logic        sec;
    int          pick;
    int          dsel;
    pick = $urandom_range(0, 99);
    if (pick < add_pct) rt = REQ_ADD;
    else if (pick < add_pct + 10) rt = REQ_KILL;
    else if (pick < add_pct + 18) rt = REQ_EXIT;
    else if (pick < add_pct + 43) rt = REQ_SLEEP;
    else if (pick < 97) rt = REQ_NEXT;
    else rt = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 49) == 0) sim_ms = $urandom;
    else sim_ms = sim_ms + $urandom_range(0, 40);
    dsel = $urandom_range(0, 9);
    if (dsel < 7) begin
      dur = 15'($urandom_range(0, 300));
      sec = 1'b0;
    end else if (dsel < 9) begin
      dur = 15'($urandom_range(0, 2));
      sec = 1'b1;
    end else begin
      dur = 15'($urandom_range(0, 32767));
      sec = 1'($urandom_range(0, 1));
    end
    send_item(rt, 3'($urandom_range(0, 7)), dur, sec, sim_ms);
  endtask

  // receiver holds off for a random number of cycles before each result while rx stalls are on
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = rx_stalls_on ? $urandom_range(0, 7) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_ADD;
    slot       <= '0;
    duration   <= '0;
    in_seconds <= 1'b0;
    now        <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table: idle pass, nothing current, kill of a free slot
    send_item(REQ_NEXT, 3'd0, 15'd0, 1'b0, 32'd0);
    send_item(REQ_EXIT, 3'd0, 15'd0, 1'b0, 32'd0);
    send_item(REQ_SLEEP, 3'd0, 15'd5, 1'b0, 32'd0);
    send_item(REQ_KILL, 3'd7, 15'd0, 1'b0, 32'd0);
    // fill every slot, then one more for the full answer
    repeat (SLOTS + 1) send_item(REQ_ADD, 3'd0, 15'd0, 1'b0, 32'd0);
    send_item(3'd5, 3'd0, 15'd0, 1'b0, 32'd0);
    send_item(3'd6, 3'd5, 15'h2AAA, 1'b1, 32'h5555_5555);
    send_item(3'd7, 3'd7, 15'h7FFF, 1'b1, 32'hFFFF_FFFF);
    // sleep in seconds from the top of time wraps round
    send_item(REQ_NEXT, 3'd0, 15'd0, 1'b0, 32'd0);
    send_item(REQ_SLEEP, 3'd0, 15'h7FFF, 1'b1, 32'hFFFF_FFFF);
    send_item(REQ_NEXT, 3'd0, 15'd0, 1'b0, 32'd0);
    send_item(REQ_SLEEP, 3'd0, 15'd0, 1'b0, 32'd0);
    // killing the running task leaves nothing current
    send_item(REQ_KILL, 3'd1, 15'd0, 1'b0, 32'd0);
    send_item(REQ_EXIT, 3'd0, 15'd0, 1'b0, 32'd0);
    send_item(REQ_NEXT, 3'd0, 15'd0, 1'b0, 32'hFFFF_FFFF);
    send_item(REQ_EXIT, 3'd0, 15'd0, 1'b0, 32'd0);
    repeat (6) send_item(REQ_NEXT, 3'd0, 15'd0, 1'b0, 32'd0);
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      tx_gaps_on   = (ph != 1);
      rx_stalls_on = (ph != 2);
      for (int n = 0; n < 350; n++) random_request((ph % 2 == 0) ? 30 : 14);
      drain_results();
    end

    repeat (2 * SLOTS + 3) @(posedge clk);
    $display("covered %0d requests and %0d checked results, with gaps and stalls on and off",
             sent, results_seen);
    $display("%0d dispatches and %0d table-full answers seen", dispatches, full_answers);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
